FILE: rtl/csvt_pkg.sv
// shared types, character codes and sizes for the csv field tokenizer
package csvt_pkg;

  // character and register widths
  localparam int unsigned CharWidthDefault = 8;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned DelimW           = 8;

  // result queue depth, must hold two results from one step plus some slack
  localparam int unsigned ResDepth = 4;

  // special characters
  localparam logic [ByteW-1:0] CH_NL    = 8'd10;
  localparam logic [ByteW-1:0] CH_CR    = 8'd13;
  localparam logic [ByteW-1:0] CH_QUOTE = 8'd34;
  localparam logic [ByteW-1:0] CH_NUL   = 8'd0;
  localparam logic [ByteW-1:0] DELIM_RESET = 8'd44;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE        = 2'd0,
    KIND_FIELD_END   = 2'd1,
    KIND_BAD_DELIM   = 2'd2,
    KIND_END_OF_DATA = 2'd3
  } kind_e;

  // one result item
  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] byte_out;
    logic             row_end;
    logic             last;
  } res_t;

  // parser flags carried from one character to the next
  typedef struct packed {
    logic inside_quotes;
    logic quote_run_odd;
    logic last_was_quote;
    logic field_has_chars;
    logic held_valid;
    logic row_has_field;
  } flags_t;

endpackage

FILE: rtl/csvt_step.sv
// per-character next-state and result logic of the tokenizer
module csvt_step #(
  parameter int unsigned CHAR_WIDTH = csvt_pkg::CharWidthDefault
) (
  input  csvt_pkg::flags_t                flags_q_i,
  input  logic [CHAR_WIDTH-1:0]           held_q_i,
  input  logic [CHAR_WIDTH-1:0]           ch_i,
  input  logic                            end_of_input_i,
  input  logic [csvt_pkg::DelimW-1:0]     delimiter_i,
  output csvt_pkg::flags_t                flags_d_o,
  output logic [CHAR_WIDTH-1:0]           held_d_o,
  output csvt_pkg::res_t                  res0_o,
  output csvt_pkg::res_t                  res1_o,
  output logic [1:0]                      res_cnt_o
);

  logic [CHAR_WIDTH-1:0] c;
  logic                  at_start;
  logic                  is_quote;
  logic                  is_nl;
  logic                  is_delim;
  logic                  bad_delim;
  csvt_pkg::res_t        byte_res;
  csvt_pkg::res_t        end_res;

  // effective character, end of input reads as newline
  assign c         = end_of_input_i ? CHAR_WIDTH'(csvt_pkg::CH_NL) : ch_i;
  assign at_start  = !flags_q_i.field_has_chars && !flags_q_i.last_was_quote;
  assign is_quote  = (c == CHAR_WIDTH'(csvt_pkg::CH_QUOTE));
  assign is_nl     = (c == CHAR_WIDTH'(csvt_pkg::CH_NL));
  assign is_delim  = (c == CHAR_WIDTH'(delimiter_i));
  assign bad_delim = delimiter_i inside {csvt_pkg::CH_NL, csvt_pkg::CH_CR,
                                         csvt_pkg::CH_NUL, csvt_pkg::CH_QUOTE};

  // held character released as a field byte
  always_comb begin
    byte_res          = '0;
    byte_res.kind     = csvt_pkg::KIND_BYTE;
    byte_res.byte_out = held_q_i[csvt_pkg::ByteW-1:0];
  end

  // field end marker, closes the row on newline
  always_comb begin
    end_res         = '0;
    end_res.kind    = csvt_pkg::KIND_FIELD_END;
    end_res.row_end = is_nl;
  end

  // state update and result selection
  always_comb begin
    flags_d_o = flags_q_i;
    held_d_o  = held_q_i;
    res0_o    = '0;
    res1_o    = '0;
    res_cnt_o = 2'd0;
    if (bad_delim) begin
      res0_o.kind = csvt_pkg::KIND_BAD_DELIM;
      res0_o.last = 1'b1;
      res_cnt_o   = 2'd1;
    end else if (end_of_input_i && !flags_q_i.field_has_chars &&
                 !flags_q_i.row_has_field) begin
      // empty row at end of stream
      flags_d_o   = '0;
      held_d_o    = '0;
      res0_o.kind = csvt_pkg::KIND_END_OF_DATA;
      res0_o.last = 1'b1;
      res_cnt_o   = 2'd1;
    end else if (!end_of_input_i && (ch_i == CHAR_WIDTH'(csvt_pkg::CH_CR))) begin
      // carriage return is dropped
    end else if (at_start && is_quote) begin
      // opening quote of a quoted field
      flags_d_o.inside_quotes  = 1'b1;
      flags_d_o.last_was_quote = 1'b1;
    end else begin
      // quote run parity, second quote of a pair cancels the held one
      if (!at_start) begin
        if (is_quote) begin
          flags_d_o.quote_run_odd = !flags_q_i.quote_run_odd;
          flags_d_o.inside_quotes = flags_q_i.quote_run_odd;
          if (flags_q_i.quote_run_odd) begin
            flags_d_o.held_valid = 1'b0;
          end
        end else begin
          flags_d_o.quote_run_odd = 1'b0;
        end
      end
      if (end_of_input_i || ((is_delim || is_nl) && !flags_d_o.inside_quotes)) begin
        // field ends, a trailing quote is removed
        if (flags_d_o.held_valid && !flags_q_i.last_was_quote) begin
          res0_o      = byte_res;
          res1_o      = end_res;
          res1_o.last = 1'b1;
          res_cnt_o   = 2'd2;
        end else begin
          res0_o      = end_res;
          res0_o.last = 1'b1;
          res_cnt_o   = 2'd1;
        end
        flags_d_o.inside_quotes   = 1'b0;
        flags_d_o.quote_run_odd   = 1'b0;
        flags_d_o.last_was_quote  = 1'b0;
        flags_d_o.field_has_chars = 1'b0;
        flags_d_o.held_valid      = 1'b0;
        flags_d_o.row_has_field   = !is_nl;
        held_d_o                  = '0;
      end else begin
        // store the character, release the previous one
        if (flags_d_o.held_valid) begin
          res0_o      = byte_res;
          res0_o.last = 1'b1;
          res_cnt_o   = 2'd1;
        end
        held_d_o                  = c;
        flags_d_o.held_valid      = 1'b1;
        flags_d_o.field_has_chars = 1'b1;
        flags_d_o.last_was_quote  = is_quote;
      end
    end
  end

endmodule

FILE: rtl/csvt_res_fifo.sv
// result queue that takes up to two results per cycle and gives one
module csvt_res_fifo #(
  parameter int unsigned DEPTH = csvt_pkg::ResDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_cnt_i,
  input  csvt_pkg::res_t push0_i,
  input  csvt_pkg::res_t push1_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output csvt_pkg::res_t out_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  csvt_pkg::res_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  // status and read side
  assign room_o      = (count_q <= CntW'(DEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // pointer and fill count update
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_cnt_i) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage write, second result goes to the following slot
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push1_i;
    end
  end

endmodule

FILE: rtl/csv_field_tokenizer_unit.sv
// csv field tokenizer top level: input register, step logic, result queue
// Latency: a character's first result passes through the input register and then the result queue.
// Throughput: one character per cycle while each gives at most one result and the result port does not stall;
//   a character that gives two results hands them out one by one at the result port.
// The step unit fires whenever the four-entry result queue has room for two results.
// Reset clears the parser flags, the held character, the queue and sets the delimiter to ','.
module csv_field_tokenizer_unit #(
  parameter int unsigned CHAR_WIDTH = csvt_pkg::CharWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [csvt_pkg::DelimW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [CHAR_WIDTH-1:0]       ch_i,
  input  logic                        end_of_input_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [csvt_pkg::ByteW-1:0]  byte_out_o,
  output logic                        row_end_o,
  output logic                        last_o
);

  logic [csvt_pkg::DelimW-1:0] delim_q;
  logic                        in_valid_q;
  logic [CHAR_WIDTH-1:0]       ch_q;
  logic                        eoi_q;
  csvt_pkg::flags_t            flags_q, flags_d;
  logic [CHAR_WIDTH-1:0]       held_q, held_d;
  csvt_pkg::res_t              res0, res1, res_out;
  logic [1:0]                  res_cnt;
  logic                        room;
  logic                        fire;
  logic                        in_xfer;

  // step fires when a character waits and the queue can take two results
  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  // delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= csvt_pkg::DELIM_RESET;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q  <= ch_i;
      eoi_q <= end_of_input_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      held_q  <= '0;
    end else if (fire) begin
      flags_q <= flags_d;
      held_q  <= held_d;
    end
  end

  csvt_step #(
    .CHAR_WIDTH(CHAR_WIDTH)
  ) u_step (
    .flags_q_i      (flags_q),
    .held_q_i       (held_q),
    .ch_i           (ch_q),
    .end_of_input_i (eoi_q),
    .delimiter_i    (delim_q),
    .flags_d_o      (flags_d),
    .held_d_o       (held_d),
    .res0_o         (res0),
    .res1_o         (res1),
    .res_cnt_o      (res_cnt)
  );

  csvt_res_fifo #(
    .DEPTH(csvt_pkg::ResDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (fire ? res_cnt : 2'd0),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res_out)
  );

  // result fields
  assign kind_o     = res_out.kind;
  assign byte_out_o = res_out.byte_out;
  assign row_end_o  = res_out.row_end;
  assign last_o     = res_out.last;

endmodule

FILE: rtl/csvt_checker.sv
// port-level checks for the csv field tokenizer and their bind
module csvt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 kind_o,
  input logic [csvt_pkg::ByteW-1:0] byte_out_o,
  input logic                       row_end_o,
  input logic                       last_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(byte_out_o) && $stable(row_end_o) && $stable(last_o))
    else $error("result changed while stalled");

  // only field bytes carry a character
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != csvt_pkg::KIND_BYTE) |-> byte_out_o == '0)
    else $error("nonzero byte on a non-byte result");

  // row end only on a field end
  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_end_o |-> kind_o == csvt_pkg::KIND_FIELD_END)
    else $error("row end on a result that is not a field end");

  // error and end of data are always the only result of their character
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == csvt_pkg::KIND_BAD_DELIM ||
                    kind_o == csvt_pkg::KIND_END_OF_DATA) |-> last_o)
    else $error("error or end of data result not marked last");

endmodule

bind csv_field_tokenizer_unit csvt_checker u_csvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .byte_out_o  (byte_out_o),
  .row_end_o   (row_end_o),
  .last_o      (last_o)
);

FILE: test/csv_field_tokenizer_unit_test.sv
// testbench for the csv field tokenizer: directed and random character streams
module csv_field_tokenizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteW         = csvt_pkg::ByteW;
  localparam int unsigned DelimW        = csvt_pkg::DelimW;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned ItemTarget    = 450;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [DelimW-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] ch_i;
  logic             end_of_input_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [1:0]       kind_o;
  logic [ByteW-1:0] byte_out_o;
  logic             row_end_o;
  logic             last_o;

  // tokenizer state mirrored by the predictor
  logic [DelimW-1:0] delim_cfg;
  logic              quoted;
  logic              run_odd;
  logic              prev_quote;
  logic              field_busy;
  logic              held_ok;
  logic [ByteW-1:0]  held_byte;
  logic              row_open;

  csvt_pkg::res_t pending_tokens[$];
  int unsigned    error_count;
  int unsigned    sent_items;
  int unsigned    quiet_cycles;
  int unsigned    stall_left;
  bit             idle_on;

  csv_field_tokenizer_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .byte_out_o     (byte_out_o),
    .row_end_o      (row_end_o),
    .last_o         (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic push_token(input csvt_pkg::kind_e k, input logic [ByteW-1:0] b,
                            input logic re);
    csvt_pkg::res_t r;
    r.kind     = k;
    r.byte_out = b;
    r.row_end  = re;
    r.last     = 1'b0;
    pending_tokens.push_back(r);
  endtask

  task automatic clear_row_state();
    quoted     = 1'b0;
    run_odd    = 1'b0;
    prev_quote = 1'b0;
    field_busy = 1'b0;
    held_ok    = 1'b0;
    held_byte  = '0;
    row_open   = 1'b0;
  endtask

  // expected tokens for one accepted character
  task automatic tokenize_char(input logic [ByteW-1:0] c_in, input logic eoi);
    logic [ByteW-1:0] c;
    logic             row_done;
    int               base;
    c    = c_in;
    base = pending_tokens.size();
    if (delim_cfg == csvt_pkg::CH_NL || delim_cfg == csvt_pkg::CH_CR ||
        delim_cfg == csvt_pkg::CH_NUL || delim_cfg == csvt_pkg::CH_QUOTE) begin
      push_token(csvt_pkg::KIND_BAD_DELIM, '0, 1'b0);
    end else if (eoi && !field_busy && !row_open) begin
      clear_row_state();
      push_token(csvt_pkg::KIND_END_OF_DATA, '0, 1'b0);
    end else if (!eoi && c == csvt_pkg::CH_CR) begin
      // carriage return is dropped
    end else if (!field_busy && !prev_quote && !eoi && c == csvt_pkg::CH_QUOTE) begin
      // opening quote of a quoted field
      quoted     = 1'b1;
      prev_quote = 1'b1;
    end else begin
      if (eoi) c = csvt_pkg::CH_NL;
      if (field_busy || prev_quote) begin
        if (c == csvt_pkg::CH_QUOTE) begin
          run_odd = ~run_odd;
          quoted  = ~run_odd;
          // second quote of a pair cancels the held one
          if (quoted) held_ok = 1'b0;
        end else begin
          run_odd = 1'b0;
        end
      end
      if (eoi || ((c == delim_cfg || c == csvt_pkg::CH_NL) && !quoted)) begin
        row_done = (c == csvt_pkg::CH_NL);
        if (held_ok && !prev_quote) push_token(csvt_pkg::KIND_BYTE, held_byte, 1'b0);
        push_token(csvt_pkg::KIND_FIELD_END, '0, row_done);
        held_ok    = 1'b0;
        held_byte  = '0;
        field_busy = 1'b0;
        quoted     = 1'b0;
        run_odd    = 1'b0;
        prev_quote = 1'b0;
        row_open   = ~row_done;
      end else begin
        if (held_ok) push_token(csvt_pkg::KIND_BYTE, held_byte, 1'b0);
        held_byte  = c;
        held_ok    = 1'b1;
        field_busy = 1'b1;
        prev_quote = (c == csvt_pkg::CH_QUOTE);
      end
    end
    if (pending_tokens.size() > base) begin
      pending_tokens[pending_tokens.size()-1].last = 1'b1;
    end
  endtask

  // one character transfer, with an optional idle burst before it
  task automatic send_char(input logic [ByteW-1:0] c, input logic eoi);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    ch_i           <= c;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
    tokenize_char(c, eoi);
    sent_items++;
  endtask

  // stop sending and wait until every expected token has come out
  task automatic wait_for_tokens();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_delimiter(input logic [DelimW-1:0] d);
    wait_for_tokens();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    delim_cfg  = d;
  endtask

  function automatic logic [ByteW-1:0] plain_char();
    logic [ByteW-1:0] c;
    c = ByteW'($urandom_range(32, 126));
    if (c == csvt_pkg::CH_QUOTE || c == delim_cfg) c = 8'h78;
    return c;
  endfunction

  // one well-formed row with random content, or now and then random noise
  task automatic send_row();
    int unsigned nfields;
    int unsigned len;
    int unsigned pick;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_char(ByteW'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
      end
      return;
    end
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
        // quoted field with embedded separators and doubled quotes
        send_char(csvt_pkg::CH_QUOTE, 1'b0);
        repeat (len) begin
          pick = $urandom_range(0, 11);
          if (pick < 2) begin
            send_char(csvt_pkg::CH_QUOTE, 1'b0);
            send_char(csvt_pkg::CH_QUOTE, 1'b0);
          end else if (pick < 4) begin
            send_char(delim_cfg, 1'b0);
          end else if (pick == 4) begin
            send_char(csvt_pkg::CH_NL, 1'b0);
          end else if (pick == 5) begin
            send_char(csvt_pkg::CH_CR, 1'b0);
          end else begin
            send_char(plain_char(), 1'b0);
          end
        end
        send_char(csvt_pkg::CH_QUOTE, 1'b0);
      end else begin
        repeat (len) begin
          pick = $urandom_range(0, 11);
          if (pick == 0) send_char(csvt_pkg::CH_QUOTE, 1'b0);
          else if (pick == 1) send_char(csvt_pkg::CH_CR, 1'b0);
          else send_char(plain_char(), 1'b0);
        end
      end
      if (f + 1 < nfields) begin
        send_char(delim_cfg, 1'b0);
      end else begin
        pick = $urandom_range(0, 4);
        if (pick == 0) begin
          send_char(ByteW'($urandom_range(0, 255)), 1'b1);
        end else begin
          if (pick == 1) send_char(csvt_pkg::CH_CR, 1'b0);
          send_char(csvt_pkg::CH_NL, 1'b0);
        end
      end
    end
  endtask

  // fixed rows covering quoting, dropped returns and end of input
  task automatic test_directed_rows();
    send_char("a", 1'b0);
    send_char(",", 1'b0);
    send_char("b", 1'b0);
    send_char(csvt_pkg::CH_CR, 1'b0);
    send_char(csvt_pkg::CH_NL, 1'b0);
    // quoted field holding a delimiter and a doubled quote
    send_char(csvt_pkg::CH_QUOTE, 1'b0);
    send_char(",", 1'b0);
    send_char(csvt_pkg::CH_QUOTE, 1'b0);
    send_char(csvt_pkg::CH_QUOTE, 1'b0);
    send_char(csvt_pkg::CH_QUOTE, 1'b0);
    send_char(csvt_pkg::CH_NL, 1'b0);
    // lone quote right before end of input
    send_char(csvt_pkg::CH_QUOTE, 1'b0);
    send_char(8'hA5, 1'b1);
    // end of input on an empty row
    send_char(8'hFF, 1'b1);
    // extreme bytes and a quote inside an unquoted field
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(csvt_pkg::CH_QUOTE, 1'b0);
    send_char(csvt_pkg::CH_QUOTE, 1'b0);
    send_char("q", 1'b0);
    send_char(8'h5A, 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  // each rejected delimiter turns every character into an error token
  task automatic test_bad_delimiter();
    logic [DelimW-1:0] bad[4];
    bad = '{csvt_pkg::CH_NL, csvt_pkg::CH_CR, csvt_pkg::CH_NUL, csvt_pkg::CH_QUOTE};
    foreach (bad[i]) begin
      set_delimiter(bad[i]);
      send_char(ByteW'($urandom_range(0, 255)), 1'b0);
      send_char(csvt_pkg::CH_QUOTE, 1'b0);
      send_char(ByteW'($urandom_range(0, 255)), 1'b1);
    end
    set_delimiter(csvt_pkg::DELIM_RESET);
  endtask

  // sender holds off mid-row until all tokens have drained
  task automatic test_drain_pause();
    send_char("x", 1'b0);
    send_char("y", 1'b0);
    wait_for_tokens();
    send_char("z", 1'b0);
    send_char(delim_cfg, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  // random rows over several delimiters, ending with no idling
  task automatic test_random_rows();
    logic [DelimW-1:0] delims[5];
    delims = '{8'd59, 8'd9, 8'd255, 8'd1, csvt_pkg::DELIM_RESET};
    foreach (delims[p]) begin
      set_delimiter(delims[p]);
      while (sent_items < 100 + p * 70) send_row();
    end
    idle_on = 1'b0;
    while (sent_items < ItemTarget) send_row();
  endtask

  // output side stalls in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each token transfer against the oldest expectation
  always @(posedge clk_i) begin
    csvt_pkg::res_t exp_tok;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        flag_error($sformatf("unexpected token kind=%0d byte=%02h row_end=%0b last=%0b",
                             kind_o, byte_out_o, row_end_o, last_o));
      end else begin
        exp_tok = pending_tokens.pop_front();
        if (kind_o !== exp_tok.kind || byte_out_o !== exp_tok.byte_out ||
            row_end_o !== exp_tok.row_end || last_o !== exp_tok.last) begin
          flag_error($sformatf({"token mismatch: expected kind=%0d byte=%02h row_end=%0b",
                                " last=%0b, got kind=%0d byte=%02h row_end=%0b last=%0b"},
                               exp_tok.kind, exp_tok.byte_out, exp_tok.row_end,
                               exp_tok.last, kind_o, byte_out_o, row_end_o, last_o));
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    ch_i           = '0;
    end_of_input_i = 1'b0;
    out_ready_i    = 1'b0;
    error_count    = 0;
    sent_items     = 0;
    quiet_cycles   = 0;
    stall_left     = 0;
    idle_on        = 1'b1;
    delim_cfg      = csvt_pkg::DELIM_RESET;
    clear_row_state();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_rows();
    test_bad_delimiter();
    test_drain_pause();
    test_random_rows();

    wait_for_tokens();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
